// ===== rtl/pbec_pkg.sv =====
package pbec_pkg;

    localparam int COORD_BITS = 32;
    localparam int DIFF_BITS  = COORD_BITS + 1;
    localparam int PROD_BITS  = 2 * DIFF_BITS;
    localparam int CFG_IDX_BITS = 2;
    localparam int QUEUE_DEPTH = 2;

    localparam logic [CFG_IDX_BITS-1:0] REG_X_LOW  = 2'd0;
    localparam logic [CFG_IDX_BITS-1:0] REG_X_HIGH = 2'd1;
    localparam logic [CFG_IDX_BITS-1:0] REG_Y_LOW  = 2'd2;
    localparam logic [CFG_IDX_BITS-1:0] REG_Y_HIGH = 2'd3;

    typedef logic signed [COORD_BITS-1:0] t_coord;
    typedef logic signed [DIFF_BITS-1:0]  t_diff;
    typedef logic signed [PROD_BITS-1:0]  t_prod;

    // one classified edge handed from front to back
    typedef struct packed {
        t_coord x0;
        t_coord y0;
        t_coord x1;
        t_coord y1;
        logic   test_edge;
        logic   first;
        logic   last;
    } t_edge;

endpackage

// ===== rtl/pbec_front.sv =====
module pbec_front (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  pbec_pkg::t_coord i_vertex_x,
    input  pbec_pkg::t_coord i_vertex_y,
    input  logic           i_first_vertex,
    input  logic           i_last_vertex,
    output logic           o_full,
    output logic           o_edge_valid,
    output pbec_pkg::t_edge o_edge,
    input  logic           i_edge_take
);
    import pbec_pkg::*;

    t_edge r_q [QUEUE_DEPTH];
    logic  r_wp, r_rp;
    logic [1:0] r_cnt;
    t_coord r_px, r_py;
    logic  r_have;
    logic  w_acc, w_take;

    assign o_full       = (r_cnt == 2'(QUEUE_DEPTH));
    assign o_edge_valid = (r_cnt != 2'd0);
    assign o_edge       = r_q[r_rp];
    assign w_acc  = i_push && !o_full;
    assign w_take = i_edge_take && o_edge_valid;

    always_ff @(posedge i_clk) begin
        if (w_acc) begin
            r_q[r_wp].x0 <= r_px;
            r_q[r_wp].y0 <= r_py;
            r_q[r_wp].x1 <= i_vertex_x;
            r_q[r_wp].y1 <= i_vertex_y;
            r_q[r_wp].test_edge <= r_have && !i_first_vertex;
            r_q[r_wp].first <= i_first_vertex;
            r_q[r_wp].last  <= i_last_vertex;
            r_px <= i_vertex_x;
            r_py <= i_vertex_y;
        end
        if (!i_rst_n) begin
            r_wp <= 1'b0;
            r_rp <= 1'b0;
            r_cnt <= 2'd0;
            r_have <= 1'b0;
        end else begin
            if (w_acc) begin
                r_wp <= ~r_wp;
                r_have <= !i_last_vertex;
            end
            if (w_take) r_rp <= ~r_rp;
            r_cnt <= r_cnt + 2'(w_acc) - 2'(w_take);
        end
    end
endmodule

// ===== rtl/pbec_back.sv =====
module pbec_back (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  pbec_pkg::t_coord i_x_low,
    input  pbec_pkg::t_coord i_x_high,
    input  pbec_pkg::t_coord i_y_low,
    input  pbec_pkg::t_coord i_y_high,
    input  logic            i_edge_valid,
    input  pbec_pkg::t_edge i_edge,
    output logic            o_edge_take,
    output logic            o_empty,
    output logic            o_box_hit,
    input  logic            i_pop
);
    import pbec_pkg::*;

    typedef enum logic [1:0] {S_IDLE, S_MUL_A, S_MUL_B, S_CMP} t_state;

    t_state r_state;
    t_edge  r_e;
    logic [1:0] r_line;
    logic   r_lim;
    logic   r_below_lo;
    logic   r_hit;
    logic   r_full;
    logic   r_res;
    t_prod  r_pa, r_pb;
    t_diff  r_d;

    // per-line operands, axes swapped for vertical lines
    t_coord w_line, w_a0, w_b0, w_a1, w_b1, w_lo, w_hi, w_limv;
    t_diff  w_d, w_ma, w_mb;
    t_prod  w_prod;
    logic   w_sidea, w_sideb, w_cross, w_below, w_new_hit;
    logic   w_start;

    always_comb begin
        w_line = i_y_low;
        w_lo = i_x_low;
        w_hi = i_x_high;
        w_a0 = r_e.x0; w_b0 = r_e.y0; w_a1 = r_e.x1; w_b1 = r_e.y1;
        case (r_line)
            2'd0: w_line = i_y_low;
            2'd1: w_line = i_y_high;
            2'd2: w_line = i_x_low;
            default: w_line = i_x_high;
        endcase
        if (r_line[1]) begin
            w_lo = i_y_low; w_hi = i_y_high;
            w_a0 = r_e.y0; w_b0 = r_e.x0; w_a1 = r_e.y1; w_b1 = r_e.x1;
        end
        w_limv = r_lim ? w_hi : w_lo;
        w_d  = DIFF_BITS'(w_b1) - DIFF_BITS'(w_b0);
        // one shared multiplier: (lim-a0)*d then (a1-a0)*(line-b0)
        if (r_state == S_MUL_A) begin
            w_ma = DIFF_BITS'(w_limv) - DIFF_BITS'(w_a0);
            w_mb = w_d;
        end else begin
            w_ma = DIFF_BITS'(w_a1) - DIFF_BITS'(w_a0);
            w_mb = DIFF_BITS'(w_line) - DIFF_BITS'(w_b0);
        end
        w_prod  = w_ma * w_mb;
        w_sidea = w_b0 > w_line;
        w_sideb = w_b1 > w_line;
        w_cross = r_e.test_edge && (w_sidea != w_sideb);
        w_below = (r_d > 0) ? (r_pa < r_pb) : (r_pa > r_pb);
        // exactly one of the two limits lies below the crossing point
        w_new_hit = r_lim && (w_below != r_below_lo);
    end

    assign w_start = (r_state == S_IDLE) && i_edge_valid && !r_full;
    assign o_edge_take = w_start;
    assign o_empty = !r_full;
    assign o_box_hit = r_res;

    always_ff @(posedge i_clk) begin
        if (w_start) r_e <= i_edge;
        if (r_state == S_MUL_A) begin
            r_pa <= w_prod;
            r_d  <= w_d;
        end
        if (r_state == S_MUL_B) r_pb <= w_prod;
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_hit <= 1'b0;
            r_full <= 1'b0;
            r_res <= 1'b0;
            r_line <= 2'd0;
            r_lim <= 1'b0;
            r_below_lo <= 1'b0;
        end else begin
            if (i_pop && r_full) r_full <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    if (w_start) begin
                        r_line <= 2'd0;
                        r_lim <= 1'b0;
                        if (i_edge.first) r_hit <= 1'b0;
                        r_state <= S_MUL_A;
                    end
                end
                S_MUL_A: begin
                    if (!w_cross || r_hit) begin
                        // nothing to test on this line
                        if (r_line == 2'd3 || r_hit) begin
                            r_state <= S_IDLE;
                            if (r_e.last) begin
                                r_full <= 1'b1;
                                r_res <= r_hit;
                                r_hit <= 1'b0;
                            end
                        end else begin
                            r_line <= r_line + 2'd1;
                        end
                    end else begin
                        r_state <= S_MUL_B;
                    end
                end
                S_MUL_B: r_state <= S_CMP;
                S_CMP: begin
                    if (!r_lim) begin
                        // low limit done, go round again for the high limit
                        r_below_lo <= w_below;
                        r_lim <= 1'b1;
                        r_state <= S_MUL_A;
                    end else begin
                        r_lim <= 1'b0;
                        if (r_line == 2'd3 || w_new_hit) begin
                            r_state <= S_IDLE;
                            if (r_e.last) begin
                                r_full <= 1'b1;
                                r_res <= w_new_hit;
                                r_hit <= 1'b0;
                            end else if (w_new_hit) begin
                                r_hit <= 1'b1;
                            end
                        end else begin
                            r_line <= r_line + 2'd1;
                            r_state <= S_MUL_A;
                        end
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end
endmodule

// ===== rtl/polyline_box_edge_crossing.sv =====
// channel  | handshake          | payload
// vertex   | i_push / o_full    | i_vertex_x, i_vertex_y, i_first_vertex, i_last_vertex
// result   | o_empty / i_pop    | o_box_hit
// config   | i_cfg_we           | i_cfg_idx, i_cfg_data
// each edge is taken in S_IDLE; one shared 33x33 multiplier then serves each crossed
// line in S_MUL_A, S_MUL_B and S_CMP (two products and a compare per limit, two
// limits); S_MUL_A skips an uncrossed line and ends the edge once a hit is known
// a two-word queue lets vertices enter while the back end works
// reset is synchronous, active low, and clears all control state and the box
// a held result word stalls the back end until popped
module polyline_box_edge_crossing (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_push,
    output logic        o_full,
    input  pbec_pkg::t_coord i_vertex_x,
    input  pbec_pkg::t_coord i_vertex_y,
    input  logic        i_first_vertex,
    input  logic        i_last_vertex,
    output logic        o_empty,
    input  logic        i_pop,
    output logic        o_box_hit,
    input  logic        i_cfg_we,
    input  logic [pbec_pkg::CFG_IDX_BITS-1:0] i_cfg_idx,
    input  pbec_pkg::t_coord i_cfg_data
);
    import pbec_pkg::*;

    t_coord r_x_low, r_x_high, r_y_low, r_y_high;
    logic   w_edge_valid, w_edge_take;
    t_edge  w_edge;

    // box registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_x_low <= '0;
            r_x_high <= '0;
            r_y_low <= '0;
            r_y_high <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_X_LOW:  r_x_low  <= i_cfg_data;
                REG_X_HIGH: r_x_high <= i_cfg_data;
                REG_Y_LOW:  r_y_low  <= i_cfg_data;
                REG_Y_HIGH: r_y_high <= i_cfg_data;
                default: ;
            endcase
        end
    end

    pbec_front u_front (
        .i_clk, .i_rst_n, .i_push,
        .i_vertex_x, .i_vertex_y, .i_first_vertex, .i_last_vertex,
        .o_full,
        .o_edge_valid(w_edge_valid),
        .o_edge(w_edge),
        .i_edge_take(w_edge_take)
    );

    pbec_back u_back (
        .i_clk, .i_rst_n,
        .i_x_low(r_x_low), .i_x_high(r_x_high),
        .i_y_low(r_y_low), .i_y_high(r_y_high),
        .i_edge_valid(w_edge_valid),
        .i_edge(w_edge),
        .o_edge_take(w_edge_take),
        .o_empty, .o_box_hit, .i_pop
    );

`ifndef SYNTHESIS
    // an edge is only taken while the front has one
    a_take_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_edge_take |-> w_edge_valid) else $error("edge taken from empty queue");
    // a waiting result stays until popped
    a_res_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!o_empty && !i_pop) |=> (!o_empty && $stable(o_box_hit)))
        else $error("result lost");
`endif
endmodule

// ===== tb/tb_polyline_box_edge_crossing.sv =====
module tb_polyline_box_edge_crossing;
    timeunit 1ns;
    timeprecision 1ps;
    import pbec_pkg::*;

    // clock and reset
    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // vertex side
    logic        i_push = 1'b0;
    logic        o_full;
    logic signed [31:0] i_vertex_x = '0;
    logic signed [31:0] i_vertex_y = '0;
    logic        i_first_vertex = 1'b0;
    logic        i_last_vertex = 1'b0;
    // result side
    logic        o_empty;
    logic        i_pop = 1'b0;
    logic        o_box_hit;
    // register port
    logic        i_cfg_we = 1'b0;
    logic [CFG_IDX_BITS-1:0] i_cfg_idx = '0;
    logic signed [31:0] i_cfg_data = '0;

    polyline_box_edge_crossing dut (.*);

    // predictor state: box and polyline progress
    logic signed [31:0] box_xl, box_xh, box_yl, box_yh;
    logic signed [31:0] last_x, last_y;
    logic               have_last, hit_sticky;

    // hit flags still to be popped, oldest first
    bit   hit_queue[$];
    int   n_err;
    int   n_words_in, n_words_out, n_hits;
    bit   drain_done;
    // push level as last driven
    bit   push_on = 1'b0;

    // directed table row; want_hit < 0 means predictor only
    typedef struct {
        logic signed [31:0] x;
        logic signed [31:0] y;
        bit first;
        bit last;
        int want_hit;
    } t_row;

    // limit strictly below the crossing point along a, exact by cross-multiplying
    function automatic bit lim_below_cross(longint lim, longint a0, longint b0,
                                           longint a1, longint b1, longint line);
        logic signed [127:0] lhs, rhs;
        longint d;
        d   = b1 - b0;
        lhs = 128'(signed'(lim - a0)) * 128'(signed'(d));
        rhs = 128'(signed'(a1 - a0)) * 128'(signed'(line - b0));
        return (d > 0) ? (lhs < rhs) : (lhs > rhs);
    endfunction

    function automatic bit crosses_line(longint line, longint a0, longint b0,
                                        longint a1, longint b1, longint lo, longint hi);
        if ((b0 > line) == (b1 > line))
            return 1'b0;
        return lim_below_cross(lo, a0, b0, a1, b1, line)
            != lim_below_cross(hi, a0, b0, a1, b1, line);
    endfunction

    function automatic bit edge_hits_box(longint x0, longint y0, longint x1, longint y1);
        return crosses_line(box_yl, x0, y0, x1, y1, box_xl, box_xh)
            || crosses_line(box_yh, x0, y0, x1, y1, box_xl, box_xh)
            || crosses_line(box_xl, y0, x0, y1, x1, box_yl, box_yh)
            || crosses_line(box_xh, y0, x0, y1, x1, box_yl, box_yh);
    endfunction

    // advance predictor by one vertex, returns 1 when a word is due
    function automatic bit predict_vertex(logic signed [31:0] x, logic signed [31:0] y,
                                          bit first, bit last, output bit hit);
        if (first) begin
            have_last  = 1'b0;
            hit_sticky = 1'b0;
        end
        if (have_last && edge_hits_box(last_x, last_y, x, y))
            hit_sticky = 1'b1;
        last_x    = x;
        last_y    = y;
        have_last = 1'b1;
        hit = hit_sticky;
        if (last) begin
            have_last  = 1'b0;
            hit_sticky = 1'b0;
        end
        return last;
    endfunction

    task automatic wait_cycles(int n);
        repeat (n) @(posedge i_clk);
    endtask

    // drop push once, only if it is still up
    task automatic push_off();
        if (push_on) begin
            i_push  <= 1'b0;
            push_on = 1'b0;
        end
    endtask

    // one vertex word through the push handshake, predicted on acceptance
    task automatic push_vertex(logic signed [31:0] x, logic signed [31:0] y,
                               bit first, bit last, int want_hit);
        bit hit;
        int gap;
        gap = $urandom_range(0, 3);
        if (gap > 0) begin
            push_off();
            wait_cycles(gap);
        end
        i_push         <= 1'b1;
        push_on        = 1'b1;
        i_vertex_x     <= x;
        i_vertex_y     <= y;
        i_first_vertex <= first;
        i_last_vertex  <= last;
        do @(posedge i_clk); while (o_full);
        n_words_in++;
        if (predict_vertex(x, y, first, last, hit)) begin
            // typed-in value must agree with the predictor as well
            if (want_hit >= 0 && want_hit != hit) begin
                $display("%0t: table row expects hit %0d, predictor %0d", $time, want_hit, hit);
                n_err++;
            end
            hit_queue = {hit_queue, hit};
        end
    endtask

    task automatic write_reg(logic [CFG_IDX_BITS-1:0] idx, logic signed [31:0] val);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        case (idx)
            REG_X_LOW:  box_xl = val;
            REG_X_HIGH: box_xh = val;
            REG_Y_LOW:  box_yl = val;
            default:    box_yh = val;
        endcase
    endtask

    // wait until all words popped, then let the back end settle
    task automatic settle();
        push_off();
        while (hit_queue.size() != 0) @(posedge i_clk);
        wait_cycles(120);
    endtask

    task automatic set_box(logic signed [31:0] xl, logic signed [31:0] xh,
                           logic signed [31:0] yl, logic signed [31:0] yh);
        settle();
        write_reg(REG_X_LOW, xl);
        write_reg(REG_X_HIGH, xh);
        write_reg(REG_Y_LOW, yl);
        write_reg(REG_Y_HIGH, yh);
        i_cfg_we <= 1'b0;
    endtask

    function automatic logic signed [31:0] rand_coord(int span);
        case ($urandom_range(0, 7))
            0:       return 32'sh7fff_ffff - $urandom_range(0, 2);
            1:       return 32'sh8000_0000 + $urandom_range(0, 2);
            2:       return $urandom;
            default: return $signed($urandom_range(0, 2 * span)) - span;
        endcase
    endfunction

    // result side: random pop stalls, compare against oldest word
    always @(posedge i_clk) begin
        if (i_rst_n && i_pop && !o_empty) begin
            n_words_out++;
            if (hit_queue.size() == 0) begin
                $display("%0t: unexpected word, actual hit %0b", $time, o_box_hit);
                n_err++;
            end else begin
                if (o_box_hit !== hit_queue[0]) begin
                    $display("%0t: box_hit mismatch, expected %0b actual %0b",
                             $time, hit_queue[0], o_box_hit);
                    n_err++;
                end
                n_hits += o_box_hit;
                void'(hit_queue.pop_front());
            end
        end
    end

    int pop_gap = 0;
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_pop <= 1'b0;
        end else if (i_pop && !o_empty) begin
            pop_gap = $urandom_range(0, 3);
            i_pop <= (pop_gap == 0);
        end else if (!i_pop) begin
            if (pop_gap > 0) pop_gap--;
            i_pop <= (pop_gap == 0);
        end
    end

    // directed polylines with a unit-ish box from -10..10
    t_row dir_rows[] = '{
        '{32'sd0,   32'sd0,   1, 1, 0},   // single vertex, no edge
        '{-32'sd20, 32'sd0,   1, 0, -1},
        '{32'sd20,  32'sd0,   0, 1, 1},   // straight through the box
        '{-32'sd20, 32'sd50,  1, 0, -1},
        '{32'sd20,  32'sd50,  0, 1, 0},   // passes above the box
        '{32'sd5,   32'sd5,   1, 0, -1},
        '{32'sd5,   32'sd5,   0, 1, 0},   // zero-length edge
        '{32'sd0,   32'sd0,   1, 0, -1},
        '{32'sd3,   32'sd4,   0, 1, 0},   // stays inside
        '{32'sd0,   32'sd0,   0, 0, -1},  // starts a new polyline without flag
        '{32'sd0,   32'sd100, 0, 0, -1},
        '{32'sd1,   32'sd1,   1, 1, 0},   // first clears the pending hit
        '{32'sh8000_0000, 32'sh8000_0000, 1, 0, -1},
        '{32'sh7fff_ffff, 32'sh7fff_ffff, 0, 1, -1}, // extreme diagonal
        '{32'sh7fff_ffff, 32'sh8000_0000, 1, 0, -1},
        '{32'sh8000_0000, 32'sh7fff_ffff, 0, 0, -1},
        '{32'sd0,   32'sd10,  0, 1, -1},  // vertex on the line itself
        '{32'sd10,  -32'sd30, 1, 0, -1},
        '{32'sd10,  32'sd30,  0, 1, -1}   // along the right boundary
    };

    initial begin
        int span;
        int len;
        box_xl = 0; box_xh = 0; box_yl = 0; box_yh = 0;
        last_x = 0; last_y = 0; have_last = 0; hit_sticky = 0;
        n_err = 0; n_words_in = 0; n_words_out = 0; n_hits = 0;
        drain_done = 0;
        wait_cycles(2);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // degenerate reset box first, then the table box
        push_vertex(-32'sd5, -32'sd5, 1, 0, -1);
        push_vertex(32'sd5, 32'sd5, 0, 1, -1);
        set_box(-32'sd10, 32'sd10, -32'sd10, 32'sd10);
        foreach (dir_rows[i])
            push_vertex(dir_rows[i].x, dir_rows[i].y, dir_rows[i].first,
                        dir_rows[i].last, dir_rows[i].want_hit);

        // random phases, box settings including extremes and inverted boxes
        for (int ph = 0; ph < 6; ph++) begin
            case (ph)
                0: set_box(32'sh8000_0000, 32'sh7fff_ffff, 32'sh8000_0000, 32'sh7fff_ffff);
                1: set_box(32'sd100, -32'sd100, 32'sd50, -32'sd50);
                2: set_box(32'sd0, 32'sd0, 32'sd0, 32'sd0);
                default: set_box($urandom, $urandom, $urandom, $urandom);
            endcase
            span = (ph == 1 || ph == 2) ? 200 : 1000;
            if (ph >= 3)
                set_box(-$signed($urandom_range(0, span)), $urandom_range(0, span),
                        -$signed($urandom_range(0, span)), $urandom_range(0, span));
            for (int n = 0; n < 90; n += len) begin
                len = $urandom_range(1, 6);
                // mostly well-formed polylines, some stray flags
                for (int k = 0; k < len; k++)
                    push_vertex(rand_coord(span), rand_coord(span),
                                (k == 0) ? ($urandom_range(0, 7) != 0) : ($urandom_range(0, 15) == 0),
                                (k == len - 1) ? ($urandom_range(0, 7) != 0) : 1'b0, -1);
                // sender holds off until everything has drained
                if (n == 30) begin
                    push_off();
                    while (hit_queue.size() != 0) @(posedge i_clk);
                end
            end
        end
        push_vertex(32'sd0, 32'sd0, 0, 1, -1);

        settle();
        $display("run covered %0d vertices, %0d result words, %0d box hits",
                 n_words_in, n_words_out, n_hits);
        $display("box settings: reset, small, full range, inverted, zero and random");
        if (n_err == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

    // watchdog
    initial begin
        #2ms;
        $display("DONE: errors detected");
        $finish;
    end

endmodule
